// ===== design/lprt_pkg.sv =====
// Shared constants, types and the arctangent table for the lidar point tagger.
// No dependencies; every other design file imports this package.
`default_nettype none

package lprt_pkg;

  // Default structural parameters.
  localparam int COORD_WIDTH_DEF = 24;
  localparam int MAX_RINGS_DEF   = 128;

  // Field widths fixed by the block's interface.
  localparam int ANGLE_CFG_W = 18;
  localparam int RCOUNT_W    = 8;
  localparam int PERIOD_W    = 20;
  localparam int RING_W      = 7;
  localparam int TIME_W      = 22;
  localparam int BRIGHT_W    = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 20;

  // Angle arithmetic width (2^-16 rad accumulator and 2^-13 rad results).
  localparam int ANG_W        = 20;
  localparam int AZ_W         = 18;
  localparam int CORDIC_STEPS = 16;

  localparam logic signed [ANG_W-1:0] PI_FX            = 20'sd25736;
  localparam logic signed [ANG_W-1:0] HALF_PI_FX       = 20'sd12868;
  localparam logic signed [ANG_W-1:0] TWO_PI_FX        = 20'sd51472;
  localparam logic signed [ANG_W-1:0] THREE_HALF_PI_FX = 20'sd38604;
  localparam logic signed [ANG_W-1:0] THREE_PI_FX      = 20'sd77208;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q16      = 20'sd102944;

  // Millidegrees per angle unit, Q16.
  localparam logic [19:0] MDEG_PER_UNIT_Q16 = 20'd458366;
  // Squared distance below which a point counts as too near.
  localparam int NEAR_LIMIT = 105;

  localparam logic signed [TIME_W-1:0] TIME_MAX = 22'sd2097151;
  localparam logic signed [TIME_W-1:0] TIME_MIN = -22'sd2097152;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RINGS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 4'd3;

  // Register reset values.
  localparam logic signed [ANGLE_CFG_W-1:0] LOWER_RST  = -18'sd15000;
  localparam logic signed [ANGLE_CFG_W-1:0] UPPER_RST  = 18'sd15000;
  localparam logic [RCOUNT_W-1:0]           RINGS_RST  = 8'd16;
  localparam logic [PERIOD_W-1:0]           PERIOD_RST = 20'd100000;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_KEPT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEAR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Control that travels with each operand down the CORDIC row.
  typedef struct packed {
    logic vld;
    logic tag;
    logic zero;
  } cordic_ctl_t;

  // Arctangent of 2^-i in 2^-16 rad (first entry is the pi/4 seed step).
  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [3:0] i);
    logic signed [ANG_W-1:0] v;
    begin
      case (i)
        4'd0:    v = 20'sd51472;
        4'd1:    v = 20'sd30386;
        4'd2:    v = 20'sd16055;
        4'd3:    v = 20'sd8150;
        4'd4:    v = 20'sd4091;
        4'd5:    v = 20'sd2047;
        4'd6:    v = 20'sd1024;
        4'd7:    v = 20'sd512;
        4'd8:    v = 20'sd256;
        4'd9:    v = 20'sd128;
        4'd10:   v = 20'sd64;
        4'd11:   v = 20'sd32;
        4'd12:   v = 20'sd16;
        4'd13:   v = 20'sd8;
        4'd14:   v = 20'sd4;
        default: v = 20'sd2;
      endcase
      return v;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/lprt_if.sv =====
// Channel interfaces: point input, tagged result and configuration write.
// Depends on lprt_pkg for field widths.
`default_nettype none

interface lprt_in_if import lprt_pkg::*; #(parameter int CW = COORD_WIDTH_DEF) ();
  logic                valid;
  logic                ready;
  logic                action;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic [BRIGHT_W-1:0] brightness;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] final_x;
  logic signed [CW-1:0] final_y;

  modport source (output valid, action, pos_x, pos_y, pos_z, brightness,
                  first_x, first_y, final_x, final_y, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, brightness,
                  first_x, first_y, final_x, final_y, output ready);
endinterface

interface lprt_out_if import lprt_pkg::*; #(parameter int CW = COORD_WIDTH_DEF) ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [RING_W-1:0]        ring;
  logic signed [TIME_W-1:0] rel_time_us;
  logic signed [CW-1:0]     out_x;
  logic signed [CW-1:0]     out_y;
  logic signed [CW-1:0]     out_z;
  logic [BRIGHT_W-1:0]      out_brightness;

  modport source (output valid, status, ring, rel_time_us, out_x, out_y, out_z,
                  out_brightness, input ready);
  modport sink   (input valid, status, ring, rel_time_us, out_x, out_y, out_z,
                  out_brightness, output ready);
endinterface

interface lprt_cfg_if import lprt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// ===== design/lprt_cordic_cell.sv =====
// One CORDIC vectoring cell: a single micro-rotation, registered.
// Depends on lprt_pkg for the arctangent table and the control struct.
`default_nettype none

module lprt_cordic_cell import lprt_pkg::*; #(
  parameter int DW   = COORD_WIDTH_DEF + 21,
  parameter int STEP = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cordic_ctl_t             ctl_i,
  input  logic signed [DW-1:0]    x_i,
  input  logic signed [DW-1:0]    y_i,
  input  logic signed [ANG_W-1:0] a_i,
  output cordic_ctl_t             ctl_o,
  output logic signed [DW-1:0]    x_o,
  output logic signed [DW-1:0]    y_o,
  output logic signed [ANG_W-1:0] a_o
);

  logic signed [DW-1:0]    x_nxt, y_nxt, xs, ys;
  logic signed [ANG_W-1:0] a_nxt;
  cordic_ctl_t             ctl_r;
  logic signed [DW-1:0]    x_r, y_r;
  logic signed [ANG_W-1:0] a_r;

  // Rotate toward the x axis; arithmetic shifts round toward minus infinity.
  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (y_i > 0) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      a_nxt = a_i + atan_tab(4'(STEP));
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      a_nxt = a_i - atan_tab(4'(STEP));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    a_r <= a_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign a_o   = a_r;

endmodule

`default_nettype wire

// ===== design/lprt_cordic_chain.sv =====
// Row of CORDIC cells giving atan2 in 2^-13 rad, one operand entering per cycle.
// Depends on lprt_pkg and lprt_cordic_cell.
`default_nettype none

module lprt_cordic_chain import lprt_pkg::*; #(
  parameter int DW = COORD_WIDTH_DEF + 21
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cordic_ctl_t             ctl_i,
  input  logic signed [DW-1:0]    x_i,
  input  logic signed [DW-1:0]    y_i,
  input  logic signed [ANG_W-1:0] a_i,
  output cordic_ctl_t             ctl_o,
  output logic signed [ANG_W-1:0] angle_o
);

  cordic_ctl_t             ctl_w [0:CORDIC_STEPS];
  logic signed [DW-1:0]    x_w   [0:CORDIC_STEPS];
  logic signed [DW-1:0]    y_w   [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] a_w   [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] a_rnd;

  assign ctl_w[0] = ctl_i;
  assign x_w[0]   = x_i;
  assign y_w[0]   = y_i;
  assign a_w[0]   = a_i;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    lprt_cordic_cell #(.DW(DW), .STEP(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_w[g]),
      .x_i   (x_w[g]),
      .y_i   (y_w[g]),
      .a_i   (a_w[g]),
      .ctl_o (ctl_w[g+1]),
      .x_o   (x_w[g+1]),
      .y_o   (y_w[g+1]),
      .a_o   (a_w[g+1])
    );
  end

  // Round to 2^-13 rad, clamp to plus or minus pi, zero vector gives zero.
  always_comb begin
    a_rnd = (a_w[CORDIC_STEPS] + 20'sd4) >>> 3;
    if (ctl_w[CORDIC_STEPS].zero) begin
      angle_o = '0;
    end else if (a_rnd > PI_FX) begin
      angle_o = PI_FX;
    end else if (a_rnd < -PI_FX) begin
      angle_o = -PI_FX;
    end else begin
      angle_o = a_rnd;
    end
  end

  assign ctl_o = ctl_w[CORDIC_STEPS];

endmodule

`default_nettype wire

// ===== design/lprt_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on lprt_pkg only for the default width.
`default_nettype none

module lprt_isqrt import lprt_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2*CW-1:0]   radicand,
  output logic [CW-1:0]     root,
  output logic              done
);

  localparam int SW = 2 * CW;
  localparam int CNTW = $clog2(CW + 1);

  logic [SW-1:0]   rem_r, res_r, bit_r, rem_nxt, res_nxt, trial;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;

  // One digit step of the classic bit-pair method.
  always_comb begin
    trial = res_r + bit_r;
    if (rem_r >= trial) begin
      rem_nxt = rem_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      rem_nxt = rem_r;
      res_nxt = res_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(CW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= radicand;
      res_r <= '0;
      bit_r <= SW'(1) << (SW - 2);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign root = res_r[CW-1:0];
  assign done = done_r;

endmodule

`default_nettype wire

// ===== design/lprt_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lprt_pkg only by house convention; shared by ring and time math.
`default_nettype none

module lprt_divider import lprt_pkg::*; #(
  parameter int NW  = 46,
  parameter int DVW = 36
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic [NW-1:0]  quotient,
  output logic           done
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DVW-1:0]  rem_r, div_r;
  logic [NW-1:0]   quo_r;
  logic [DVW:0]    trial;
  logic            take;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem_r, quo_r[NW-1]};
    take  = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= take ? DVW'(trial - {1'b0, div_r}) : DVW'(trial);
      quo_r <= {quo_r[NW-2:0], take};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// ===== design/lidar_point_ring_and_time_tagger.sv =====
// Top level of the lidar point ring and time tagger: sequencer, state and config.
// Depends on lprt_pkg, lprt_if, lprt_cordic_chain, lprt_isqrt and lprt_divider.
//
//   Channel  | Dir | Handshake     | Beat carries
//   in_bus   | in  | valid/ready   | action, raw point, brightness, sweep end points
//   out_bus  | out | valid/ready   | status, ring, rel_time_us, swapped point, brightness
//   cfg_bus  | in  | valid/ready   | reg_index, data (ready is always high)
//
// A begin beat sends two atan2 operands into the 16-cell CORDIC row back to
// back. In a point beat the square root and the two 46-bit divisions are bit
// serial and dominate. One item is worked at a time; a new beat is taken once
// the previous result sits in the output register. Reset (rst_n low,
// synchronous) restores registers and sweep state; there is no clearing pass.
// A stalled output holds its beat and the sequencer waits.
`default_nettype none

module lidar_point_ring_and_time_tagger import lprt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int MAX_RINGS   = MAX_RINGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lprt_in_if.sink     in_bus,
  lprt_out_if.source  out_bus,
  lprt_cfg_if.sink    cfg_bus
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 21;
  localparam int SQW  = 2 * CW;
  localparam int MW   = 37;
  localparam int NUMW = 47;
  localparam int NW   = 46;
  localparam int DVW  = 36;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_BEG_ISS  = 4'd1;
  localparam logic [3:0] S_BEG_WAIT = 4'd2;
  localparam logic [3:0] S_SQ_X     = 4'd3;
  localparam logic [3:0] S_SQ_Y     = 4'd4;
  localparam logic [3:0] S_SQ_Z     = 4'd5;
  localparam logic [3:0] S_NEAR     = 4'd6;
  localparam logic [3:0] S_SQRT     = 4'd7;
  localparam logic [3:0] S_ANG_WAIT = 4'd8;
  localparam logic [3:0] S_RING_M   = 4'd9;
  localparam logic [3:0] S_RING_N   = 4'd10;
  localparam logic [3:0] S_DIV_RING = 4'd11;
  localparam logic [3:0] S_ORI      = 4'd12;
  localparam logic [3:0] S_TIME_P   = 4'd13;
  localparam logic [3:0] S_DIV_TIME = 4'd14;
  localparam logic [3:0] S_OUT      = 4'd15;

  logic [3:0] state_r, state_nxt;

  // Configuration registers.
  logic signed [ANGLE_CFG_W-1:0] lo_r, hi_r;
  logic [RCOUNT_W-1:0]           rc_r;
  logic [PERIOD_W-1:0]           sp_r;

  // Sweep state.
  logic signed [AZ_W-1:0] start_r, end_r, start_nxt, end_nxt;
  logic                   hp_r, hp_nxt;

  // Latched input beat.
  logic                  act_r;
  logic signed [CW-1:0]  px_r, py_r, pz_r, fx_r, fy_r;
  logic [BRIGHT_W-1:0]   br_r;

  // Working registers.
  logic [SQW-1:0]           sqxy_r, sq_r, sqxy_nxt, sq_nxt;
  logic signed [ANG_W-1:0]  az0_r, az1_r;
  logic                     got0_r, got1_r;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic [RING_W-1:0]        ring_r, ring_nxt;
  logic signed [TIME_W-1:0] rel_r, rel_nxt;
  logic signed [MW-1:0]     m_r, m_nxt;
  logic signed [NUMW-1:0]   num_r, num_nxt;
  logic [DVW-1:0]           dvs_r, dvs_nxt;
  logic                     div_go_r, div_go_nxt;
  logic signed [ANG_W-1:0]  ori_r, ori_nxt;

  // Output register.
  logic                     ov_r;
  logic [STATUS_W-1:0]      o_status_r;
  logic [RING_W-1:0]        o_ring_r;
  logic signed [TIME_W-1:0] o_rel_r;
  logic signed [CW-1:0]     o_x_r, o_y_r, o_z_r;
  logic [BRIGHT_W-1:0]      o_br_r;

  logic in_acc, out_load;

  // Shared units.
  logic              sq_start, sq_done;
  logic [CW-1:0]     sq_root;
  logic [NW-1:0]     dv_quot, dv_dividend;
  logic              dv_done;

  // CORDIC issue.
  cordic_ctl_t             ch_ctl_i, ch_ctl_o;
  logic signed [DW-1:0]    ch_x, ch_y;
  logic signed [ANG_W-1:0] ch_a, ch_angle;
  logic signed [CW:0]      op_x, op_y;
  logic                    iss_vld, iss_tag;
  logic signed [DW-1:0]    sx, sy;

  // Arithmetic helpers.
  logic signed [CW-1:0]      mul_op;
  logic signed [SQW-1:0]     mul_p;
  logic signed [40:0]        e_prod;
  logic signed [ANG_W-1:0]   hl_diff;
  logic signed [8:0]         nm1;
  logic signed [ANG_W-1:0]   st_ext, en_ext, span, o0, o1;
  logic signed [ANG_W-1:0]   bs, bf, bd;
  logic                      q_neg;
  logic                      ring_bad;

  assign in_acc        = in_bus.valid && in_bus.ready;
  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign out_load      = (state_r == S_OUT) && (!ov_r || out_bus.ready);

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= LOWER_RST;
      hi_r <= UPPER_RST;
      rc_r <= RINGS_RST;
      sp_r <= PERIOD_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.reg_index)
        CFG_LOWER:  lo_r <= cfg_bus.data[ANGLE_CFG_W-1:0];
        CFG_UPPER:  hi_r <= cfg_bus.data[ANGLE_CFG_W-1:0];
        CFG_RINGS:  rc_r <= cfg_bus.data[RCOUNT_W-1:0];
        CFG_PERIOD: sp_r <= cfg_bus.data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // CORDIC operand select: sweep end points, point azimuth, point elevation.
  always_comb begin
    iss_vld = 1'b0;
    iss_tag = 1'b0;
    op_x    = '0;
    op_y    = '0;
    if (in_acc && !in_bus.action) begin
      iss_vld = 1'b1;
      op_x    = (CW+1)'(in_bus.first_x);
      op_y    = (CW+1)'(in_bus.first_y);
    end else if (in_acc) begin
      iss_vld = 1'b1;
      iss_tag = 1'b1;
      op_x    = (CW+1)'(in_bus.pos_x);
      op_y    = (CW+1)'(in_bus.pos_y);
    end else if (state_r == S_BEG_ISS) begin
      iss_vld = 1'b1;
      iss_tag = 1'b1;
      op_x    = (CW+1)'(fx_r);
      op_y    = (CW+1)'(fy_r);
    end else if (state_r == S_SQRT && sq_done) begin
      iss_vld = 1'b1;
      op_x    = $signed({1'b0, sq_root});
      op_y    = (CW+1)'(pz_r);
    end
  end

  // Scale by 2^16 and pre-rotate the left half plane.
  always_comb begin
    sx = DW'(op_x) <<< 16;
    sy = DW'(op_y) <<< 16;
    ch_x = sx;
    ch_y = sy;
    ch_a = '0;
    if (sx < 0) begin
      if (sy >= 0) begin
        ch_x = sy;
        ch_y = -sx;
        ch_a = HALF_PI_Q16;
      end else begin
        ch_x = -sy;
        ch_y = sx;
        ch_a = -HALF_PI_Q16;
      end
    end
    ch_ctl_i.vld  = iss_vld;
    ch_ctl_i.tag  = iss_tag;
    ch_ctl_i.zero = (op_x == '0) && (op_y == '0);
  end

  lprt_cordic_chain #(.DW(DW)) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ch_ctl_i),
    .x_i     (ch_x),
    .y_i     (ch_y),
    .a_i     (ch_a),
    .ctl_o   (ch_ctl_o),
    .angle_o (ch_angle)
  );

  assign sq_start = (state_r == S_NEAR) && (sq_r >= SQW'(NEAR_LIMIT));

  lprt_isqrt #(.CW(CW)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sqxy_r),
    .root     (sq_root),
    .done     (sq_done)
  );

  assign q_neg       = num_r[NUMW-1];
  assign dv_dividend = q_neg ? NW'(-num_r) : NW'(num_r);

  lprt_divider #(.NW(NW), .DVW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (dv_dividend),
    .divisor  (dvs_r),
    .quotient (dv_quot),
    .done     (dv_done)
  );

  // Squares share one multiplier across the S_SQ_X, S_SQ_Y and S_SQ_Z states.
  always_comb begin
    case (state_r)
      S_SQ_X:  mul_op = px_r;
      S_SQ_Y:  mul_op = py_r;
      default: mul_op = pz_r;
    endcase
    mul_p = SQW'(mul_op) * SQW'(mul_op);
  end

  // Datapath helpers for ring, azimuth and sweep math.
  always_comb begin
    e_prod  = 41'(az0_r) * 41'($signed({1'b0, MDEG_PER_UNIT_Q16}));
    hl_diff = ANG_W'(hi_r) - ANG_W'(lo_r);
    nm1     = $signed({1'b0, rc_r}) - 9'sd1;
    st_ext  = ANG_W'(start_r);
    en_ext  = ANG_W'(end_r);
    span    = en_ext - st_ext;
    ring_bad = (q_neg && dv_quot != '0) ||
               (!q_neg && dv_quot >= NW'(rc_r)) ||
               (!q_neg && dv_quot >= NW'(MAX_RINGS));
    // Azimuth unwrap.
    o0 = -az1_r;
    o1 = o0;
    hp_nxt = hp_r;
    if (!hp_r) begin
      if (o0 < st_ext - HALF_PI_FX) begin
        o1 = o0 + TWO_PI_FX;
      end else if (o0 > st_ext + THREE_HALF_PI_FX) begin
        o1 = o0 - TWO_PI_FX;
      end
      if (o1 - st_ext > PI_FX) begin
        hp_nxt = 1'b1;
      end
    end else begin
      o0 = o0 + TWO_PI_FX;
      o1 = o0;
      if (o0 < en_ext - THREE_HALF_PI_FX) begin
        o1 = o0 + TWO_PI_FX;
      end else if (o0 > en_ext + HALF_PI_FX) begin
        o1 = o0 - TWO_PI_FX;
      end
    end
    ori_nxt = o1;
    // Sweep start and end with the wrap rules.
    bs = -az0_r;
    bf = -az1_r + TWO_PI_FX;
    bd = bf - bs;
    if (bd > THREE_PI_FX) begin
      bf = bf - TWO_PI_FX;
    end else if (bd < PI_FX) begin
      bf = bf + TWO_PI_FX;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    sqxy_nxt   = sqxy_r;
    sq_nxt     = sq_r;
    status_nxt = status_r;
    ring_nxt   = ring_r;
    rel_nxt    = rel_r;
    m_nxt      = m_r;
    num_nxt    = num_r;
    dvs_nxt    = dvs_r;
    div_go_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = ST_KEPT;
          ring_nxt   = '0;
          rel_nxt    = '0;
          state_nxt  = in_bus.action ? S_SQ_X : S_BEG_ISS;
        end
      end
      S_BEG_ISS: state_nxt = S_BEG_WAIT;
      S_BEG_WAIT: begin
        if (got0_r && got1_r) begin
          start_nxt = AZ_W'(bs);
          end_nxt   = AZ_W'(bf);
          state_nxt = S_IDLE;
        end
      end
      S_SQ_X: begin
        sqxy_nxt  = SQW'(mul_p);
        state_nxt = S_SQ_Y;
      end
      S_SQ_Y: begin
        sqxy_nxt  = sqxy_r + SQW'(mul_p);
        state_nxt = S_SQ_Z;
      end
      S_SQ_Z: begin
        sq_nxt    = sqxy_r + SQW'(mul_p);
        state_nxt = S_NEAR;
      end
      S_NEAR: begin
        if (sq_r < SQW'(NEAR_LIMIT)) begin
          status_nxt = ST_NEAR;
          state_nxt  = S_ANG_WAIT;
        end else begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          state_nxt = S_ANG_WAIT;
        end
      end
      S_ANG_WAIT: begin
        if (got1_r && (got0_r || status_r != ST_KEPT)) begin
          state_nxt = (status_r != ST_KEPT) ? S_OUT : S_RING_M;
        end
      end
      S_RING_M: begin
        if (hi_r <= lo_r) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_OUT;
        end else begin
          m_nxt     = MW'(e_prod) - (MW'(lo_r) <<< 16);
          state_nxt = S_RING_N;
        end
      end
      S_RING_N: begin
        num_nxt    = ((NUMW'(m_r) * NUMW'(nm1)) <<< 1) + (NUMW'(hl_diff) <<< 16);
        dvs_nxt    = DVW'(hl_diff) << 17;
        div_go_nxt = 1'b1;
        state_nxt  = S_DIV_RING;
      end
      S_DIV_RING: begin
        if (dv_done) begin
          if (ring_bad) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_OUT;
          end else begin
            ring_nxt  = dv_quot[RING_W-1:0];
            state_nxt = S_ORI;
          end
        end
      end
      S_ORI: state_nxt = S_TIME_P;
      S_TIME_P: begin
        if (span <= 0) begin
          state_nxt = S_OUT;
        end else begin
          num_nxt    = NUMW'($signed({1'b0, sp_r})) * NUMW'(ori_r - st_ext);
          dvs_nxt    = DVW'(span);
          div_go_nxt = 1'b1;
          state_nxt  = S_DIV_TIME;
        end
      end
      S_DIV_TIME: begin
        if (dv_done) begin
          if (q_neg) begin
            rel_nxt = (dv_quot > NW'(2097152)) ? TIME_MIN : TIME_W'(-$signed({1'b0, dv_quot}));
          end else begin
            rel_nxt = (dv_quot > NW'(2097151)) ? TIME_MAX : TIME_W'(dv_quot);
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and sweep state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      start_r  <= '0;
      end_r    <= AZ_W'(TWO_PI_FX);
      hp_r     <= 1'b0;
      got0_r   <= 1'b0;
      got1_r   <= 1'b0;
      div_go_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      div_go_r <= div_go_nxt;
      if (state_r == S_BEG_WAIT && got0_r && got1_r) begin
        hp_r <= 1'b0;
      end else if (state_r == S_ORI) begin
        hp_r <= hp_nxt;
      end
      if (in_acc) begin
        got0_r <= 1'b0;
        got1_r <= 1'b0;
      end else if (ch_ctl_o.vld) begin
        if (ch_ctl_o.tag) begin
          got1_r <= 1'b1;
        end else begin
          got0_r <= 1'b1;
        end
      end
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_bus.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_bus.action;
      px_r  <= in_bus.pos_x;
      py_r  <= in_bus.pos_y;
      pz_r  <= in_bus.pos_z;
      br_r  <= in_bus.brightness;
      fx_r  <= in_bus.final_x;
      fy_r  <= in_bus.final_y;
    end
    if (ch_ctl_o.vld) begin
      if (ch_ctl_o.tag) begin
        az1_r <= ch_angle;
      end else begin
        az0_r <= ch_angle;
      end
    end
    sqxy_r   <= sqxy_nxt;
    sq_r     <= sq_nxt;
    status_r <= status_nxt;
    ring_r   <= ring_nxt;
    rel_r    <= rel_nxt;
    m_r      <= m_nxt;
    num_r    <= num_nxt;
    dvs_r    <= dvs_nxt;
    if (state_r == S_ORI) begin
      ori_r <= ori_nxt;
    end
    if (out_load) begin
      o_status_r <= status_r;
      o_ring_r   <= ring_r;
      o_rel_r    <= rel_r;
      o_x_r      <= py_r;
      o_y_r      <= pz_r;
      o_z_r      <= px_r;
      o_br_r     <= br_r;
    end
  end

  assign out_bus.valid          = ov_r;
  assign out_bus.status         = o_status_r;
  assign out_bus.ring           = o_ring_r;
  assign out_bus.rel_time_us    = o_rel_r;
  assign out_bus.out_x          = o_x_r;
  assign out_bus.out_y          = o_y_r;
  assign out_bus.out_z          = o_z_r;
  assign out_bus.out_brightness = o_br_r;

  // A result beat only appears after the output state loads it.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == S_OUT))
    else $error("result beat raised outside the output state");

  // Divider completions only land in the states that wait for them.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (state_r == S_DIV_RING || state_r == S_DIV_TIME))
    else $error("divider finished with no consumer");

  // The sweep span stays at least pi, so the time division is always defined.
  a_span_pos: assert property (@(posedge clk) disable iff (!rst_n)
    span >= PI_FX)
    else $error("sweep span fell below pi");

  // A begin beat leaves the half-passed flag clear and its begin action latched.
  a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BEG_WAIT && state_nxt == S_IDLE) |=> !hp_r && !act_r)
    else $error("begin beat left half-passed set");

  // Rejected points carry no ring and no time.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_status_r != ST_KEPT) |-> (o_ring_r == '0 && o_rel_r == '0))
    else $error("rejected point carries ring or time");

endmodule

`default_nettype wire

// ===== sim/tb_lidar_point_ring_and_time_tagger.sv =====
// Self-checking testbench for lidar_point_ring_and_time_tagger.
// Depends on lprt_pkg, the lprt_if channel interfaces and the design top level.
// A scoreboard class predicts each result beat and checks the block's output.
`default_nettype none

module tb_lidar_point_ring_and_time_tagger;
  import lprt_pkg::*;

  // One input beat as the sender drives it.
  typedef struct packed {
    logic                     action;
    logic signed [23:0]       pos_x;
    logic signed [23:0]       pos_y;
    logic signed [23:0]       pos_z;
    logic [BRIGHT_W-1:0]      brightness;
    logic signed [23:0]       first_x;
    logic signed [23:0]       first_y;
    logic signed [23:0]       final_x;
    logic signed [23:0]       final_y;
  } point_beat_t;

  // One tagged result beat.
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [RING_W-1:0]        ring;
    logic signed [TIME_W-1:0] rel_time_us;
    logic signed [23:0]       out_x;
    logic signed [23:0]       out_y;
    logic signed [23:0]       out_z;
    logic [BRIGHT_W-1:0]      out_brightness;
  } tagged_point_t;

  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_POINT = 1'b1;
  localparam longint CMAX = 8388607;
  localparam longint CMIN = -8388608;

  // Predicts tagged points from accepted beats and checks the output beats.
  class tag_scoreboard;
    tagged_point_t             expected_q[$];
    int                        errors;
    logic signed [17:0]        lower_mdeg;
    logic signed [17:0]        upper_mdeg;
    logic [7:0]                rings;
    logic [19:0]               period_us;
    longint                    sweep_start;
    longint                    sweep_end;
    bit                        past_half;

    function new();
      errors      = 0;
      lower_mdeg  = LOWER_RST;
      upper_mdeg  = UPPER_RST;
      rings       = RINGS_RST;
      period_us   = PERIOD_RST;
      sweep_start = 0;
      sweep_end   = longint'(TWO_PI_FX);
      past_half   = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LOWER:  lower_mdeg = data[17:0];
        CFG_UPPER:  upper_mdeg = data[17:0];
        CFG_RINGS:  rings = data[7:0];
        CFG_PERIOD: period_us = data[19:0];
        default: ;
      endcase
    endfunction

    // Vectoring CORDIC arctangent in 2^-13 rad, floor shifts throughout.
    function longint vector_angle(longint y, longint x);
      longint a, t, xs, ys;
      longint steps[16];
      steps = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2};
      a = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 65536;
      y = y * 65536;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; a = longint'(HALF_PI_Q16);
        end else begin
          t = x; x = -y; y = t; a = -longint'(HALF_PI_Q16);
        end
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; a += steps[i];
        end else begin
          x -= ys; y += xs; a -= steps[i];
        end
      end
      a = (a + 4) >>> 3;
      if (a > longint'(PI_FX)) a = longint'(PI_FX);
      if (a < -longint'(PI_FX)) a = -longint'(PI_FX);
      return a;
    endfunction

    function longint floor_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return longint'(res);
    endfunction

    function void note_input(point_beat_t b);
      longint s, f, px, py, pz, e, lo, hi, n, num, den, ring, rel, ori, span;
      longint unsigned sq;
      logic [STATUS_W-1:0] st;
      tagged_point_t r;
      // A begin beat only moves the sweep state.
      if (b.action == ACT_BEGIN) begin
        s = -vector_angle(longint'(b.first_y), longint'(b.first_x));
        f = -vector_angle(longint'(b.final_y), longint'(b.final_x)) + longint'(TWO_PI_FX);
        if (f - s > longint'(THREE_PI_FX)) f -= longint'(TWO_PI_FX);
        else if (f - s < longint'(PI_FX)) f += longint'(TWO_PI_FX);
        sweep_start = s;
        sweep_end   = f;
        past_half   = 1'b0;
        return;
      end
      px = longint'(b.pos_x);
      py = longint'(b.pos_y);
      pz = longint'(b.pos_z);
      ring = 0;
      rel  = 0;
      st   = ST_KEPT;
      sq = longint'(px * px + py * py + pz * pz);
      if (sq < NEAR_LIMIT) begin
        st = ST_NEAR;
      end else begin
        e  = vector_angle(pz, floor_sqrt(px * px + py * py));
        lo = longint'(lower_mdeg);
        hi = longint'(upper_mdeg);
        n  = longint'(rings);
        if (hi <= lo) begin
          st = ST_RANGE;
        end else begin
          num  = (e * longint'(MDEG_PER_UNIT_Q16) - lo * 65536) * (n - 1);
          den  = (hi - lo) * 65536;
          ring = (2 * num + den) / (2 * den);
          if (ring < 0 || ring >= n || ring >= 128) st = ST_RANGE;
        end
      end
      // Azimuth unwrap and relative time for kept points only.
      if (st == ST_KEPT) begin
        ori = -vector_angle(py, px);
        if (!past_half) begin
          if (ori < sweep_start - longint'(HALF_PI_FX)) ori += longint'(TWO_PI_FX);
          else if (ori > sweep_start + longint'(THREE_HALF_PI_FX))
            ori -= longint'(TWO_PI_FX);
          if (ori - sweep_start > longint'(PI_FX)) past_half = 1'b1;
        end else begin
          ori += longint'(TWO_PI_FX);
          if (ori < sweep_end - longint'(THREE_HALF_PI_FX)) ori += longint'(TWO_PI_FX);
          else if (ori > sweep_end + longint'(HALF_PI_FX)) ori -= longint'(TWO_PI_FX);
        end
        span = sweep_end - sweep_start;
        if (span > 0) rel = (longint'(period_us) * (ori - sweep_start)) / span;
        if (rel > longint'(TIME_MAX)) rel = longint'(TIME_MAX);
        if (rel < longint'(TIME_MIN)) rel = longint'(TIME_MIN);
      end else begin
        ring = 0;
        rel  = 0;
      end
      r.status         = st;
      r.ring           = ring[RING_W-1:0];
      r.rel_time_us    = rel[TIME_W-1:0];
      r.out_x          = b.pos_y;
      r.out_y          = b.pos_z;
      r.out_z          = b.pos_x;
      r.out_brightness = b.brightness;
      expected_q.push_back(r);
    endfunction

    function void check(tagged_point_t got);
      tagged_point_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result beat with no expected point: status %0d", got.status);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status); errors++;
      end
      if (got.ring !== exp_r.ring) begin
        $error("ring: expected %0d, got %0d", exp_r.ring, got.ring); errors++;
      end
      if (got.rel_time_us !== exp_r.rel_time_us) begin
        $error("rel_time_us: expected %0d, got %0d", exp_r.rel_time_us, got.rel_time_us);
        errors++;
      end
      if (got.out_x !== exp_r.out_x) begin
        $error("out_x: expected %0d, got %0d", exp_r.out_x, got.out_x); errors++;
      end
      if (got.out_y !== exp_r.out_y) begin
        $error("out_y: expected %0d, got %0d", exp_r.out_y, got.out_y); errors++;
      end
      if (got.out_z !== exp_r.out_z) begin
        $error("out_z: expected %0d, got %0d", exp_r.out_z, got.out_z); errors++;
      end
      if (got.out_brightness !== exp_r.out_brightness) begin
        $error("out_brightness: expected %0d, got %0d", exp_r.out_brightness,
               got.out_brightness);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  lprt_in_if  in_bus ();
  lprt_out_if out_bus ();
  lprt_cfg_if cfg_bus ();

  tag_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_trig;
  int hold_seen;
  int hold_left;
  int beats_sent;

  lidar_point_ring_and_time_tagger i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("** lidar_point_ring_and_time_tagger: FAILED **");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    out_bus.ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    tagged_point_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.status         = out_bus.status;
      got.ring           = out_bus.ring;
      got.rel_time_us    = out_bus.rel_time_us;
      got.out_x          = out_bus.out_x;
      got.out_y          = out_bus.out_y;
      got.out_z          = out_bus.out_z;
      got.out_brightness = out_bus.out_brightness;
      sb.check(got);
    end
  end

  // Sends one beat, with a random idle gap ahead of it.
  task automatic push_beat(point_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.action     <= b.action;
    in_bus.pos_x      <= b.pos_x;
    in_bus.pos_y      <= b.pos_y;
    in_bus.pos_z      <= b.pos_z;
    in_bus.brightness <= b.brightness;
    in_bus.first_x    <= b.first_x;
    in_bus.first_y    <= b.first_y;
    in_bus.final_x    <= b.final_x;
    in_bus.final_y    <= b.final_y;
    in_bus.valid      <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(b);
    beats_sent++;
  endtask

  function automatic point_beat_t noise_beat();
    point_beat_t b;
    b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return b;
  endfunction

  function automatic point_beat_t make_point(longint x, longint y, longint z,
                                            logic [15:0] br);
    point_beat_t b;
    b = noise_beat();
    b.action = ACT_POINT;
    b.pos_x = x[23:0];
    b.pos_y = y[23:0];
    b.pos_z = z[23:0];
    b.brightness = br;
    return b;
  endfunction

  function automatic point_beat_t make_begin(longint fx, longint fy, longint lx,
                                            longint ly);
    point_beat_t b;
    b = noise_beat();
    b.action = ACT_BEGIN;
    b.first_x = fx[23:0];
    b.first_y = fy[23:0];
    b.final_x = lx[23:0];
    b.final_y = ly[23:0];
    return b;
  endfunction

  // Waits out every pending result, then the time a trailing begin beat needs.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
    cfg_bus.reg_index <= idx;
    cfg_bus.data      <= value[CFG_DATA_W-1:0];
    cfg_bus.valid     <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_reg(idx, value[CFG_DATA_W-1:0]);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One sweep as the sensor delivers it: begin beat, then points turning
  // through one revolution at elevations around the configured fan.
  task automatic run_sweep(int npts);
    real st, az, el, r, lo_deg, hi_deg;
    longint hx, hy;
    st = ($urandom_range(62831) - 31415) / 10000.0;
    r = 5000.0;
    push_beat(make_begin($rtoi(r * $cos(-st)), $rtoi(r * $sin(-st)),
                         $rtoi(r * $cos(-(st - 0.05))), $rtoi(r * $sin(-(st - 0.05)))));
    lo_deg = sb.lower_mdeg / 1000.0 - 3.0;
    hi_deg = sb.upper_mdeg / 1000.0 + 3.0;
    if (lo_deg < -80.0) lo_deg = -80.0;
    if (hi_deg > 80.0) hi_deg = 80.0;
    if (hi_deg < lo_deg) hi_deg = lo_deg + 1.0;
    for (int i = 0; i < npts; i++) begin
      az = st + 6.2 * i / npts + ($urandom_range(200) - 100) / 2000.0;
      el = lo_deg + (hi_deg - lo_deg) * $urandom_range(10000) / 10000.0;
      r  = 200.0 + $urandom_range(200000);
      hx = $rtoi(r * $cos(-az));
      hy = $rtoi(r * $sin(-az));
      push_beat(make_point(hx, hy, $rtoi(r * $tan(el * 3.14159265 / 180.0)),
                           $urandom_range(65535)));
    end
  endtask

  task automatic run_phase(int target);
    int stop;
    stop = beats_sent + target;
    while (beats_sent < stop) begin
      if ($urandom_range(99) < 15) push_beat(noise_beat());
      else run_sweep($urandom_range(8, 30));
    end
  endtask

  task automatic configure(longint lo, longint hi, longint n, longint per);
    write_reg(CFG_LOWER, lo);
    write_reg(CFG_UPPER, hi);
    write_reg(CFG_RINGS, n);
    write_reg(CFG_PERIOD, per);
  endtask

  initial begin
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_trig  = 0;
    beats_sent = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    {in_bus.action, in_bus.pos_x, in_bus.pos_y, in_bus.pos_z, in_bus.brightness,
     in_bus.first_x, in_bus.first_y, in_bus.final_x, in_bus.final_y} = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.reg_index = CFG_LOWER;
    cfg_bus.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at reset settings: points before any begin, origin,
    // near-distance boundary, extremes, left half-plane and sweep wrap cases.
    push_beat(make_point(5000, -3000, 200, 16'h0000));
    push_beat(make_point(0, 0, 0, 16'hFFFF));
    push_beat(make_point(10, 2, 0, 16'h1234));
    push_beat(make_point(10, 2, 1, 16'h8000));
    push_beat(make_point(CMAX, CMAX, CMAX, 16'hFFFF));
    push_beat(make_point(CMIN, CMIN, CMIN, 16'h0001));
    push_beat(make_point(0, 0, CMIN, 16'h00FF));
    push_beat(make_point(-4000, 0, 100, 16'h5555));
    push_beat(make_point(-4000, -1, 100, 16'hAAAA));
    push_beat(make_begin(0, 0, 0, 0));
    push_beat(make_point(0, 4000, 0, 16'h0F0F));
    push_beat(make_begin(CMIN, 0, CMIN, -1));
    push_beat(make_point(-3000, 10, -50, 16'h7777));
    push_beat(make_begin(CMAX, CMIN, CMIN, CMAX));
    push_beat(make_begin(1000, 0, 1000, 1));
    push_beat(make_point(1000, 0, 0, 16'h0101));
    push_beat(make_point(-1000, -5, 0, 16'h0202));
    push_beat(make_point(1000, 10, 0, 16'h0303));
    push_beat(make_point(0, -1000, 0, 16'h0404));
    push_beat(make_begin(-1000, 0, 1000, 1));
    push_beat(make_point(0, 1000, 0, 16'h0505));
    push_beat(make_point(1000, 0, 0, 16'h0606));
    run_phase(170);
    drain();

    // Widest fan, most rings, longest sweep; sender idles.
    configure(-90000, 90000, 128, 1000000);
    send_idle_pct = 57;
    run_phase(190);
    drain();

    // Fewest rings and shortest sweep; receiver stalls.
    configure(-2000, 2000, 2, 1000);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    run_phase(190);
    drain();

    // Both sides idle; a long receiver hold-off fills the block.
    configure(-30000, 10000, 64, 50000);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    hold_trig++;
    run_phase(190);
    drain();

    // Bounds equal: every far point is out of range.
    configure(10000, 10000, 32, 100000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_phase(120);
    drain();

    configure(-24900, 2000, 32, 100000);
    send_idle_pct = 57;
    run_phase(180);
    drain();

    configure(89000, 90000, 5, 999999);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    run_phase(120);
    drain();

    configure(-90000, -89000, 128, 1000);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    run_phase(100);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** lidar_point_ring_and_time_tagger: PASSED **");
    end else begin
      $display("** lidar_point_ring_and_time_tagger: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
